/* hw/rtl/selective_repeat_receive_window_defines.svh */
// ----------------------------------------------------------------------------
// selective repeat receive window assertion macros
// shared property wrappers for the receive window checks
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SRRW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SRRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/srrw_pkg.sv */
// ----------------------------------------------------------------------------
// srrw_pkg
// widths, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package srrw_pkg;

  // field widths
  localparam int SEQ_W       = 8;
  localparam int MAP_W       = 32;
  localparam int POS_W       = 5;
  localparam int RUN_W       = 6;
  localparam int CNT_W       = 5;
  localparam int FREE_W      = 5;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // window capacity
  localparam logic [FREE_W-1:0] WINDOW_SLOTS = 5'd31;

  // result status codes
  localparam logic [ST_W-1:0] ST_IGNORED   = 2'd0;
  localparam logic [ST_W-1:0] ST_BUFFERED  = 2'd1;
  localparam logic [ST_W-1:0] ST_DELIVERED = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;      // latch the incoming sequence number
    logic eval_commit;  // commit ignore/buffer decision and load result
    logic walk_start;   // load the rotated map for the release walk
    logic walk_commit;  // commit released run and load result
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic deliver;      // the latched number is the next expected one
  } dp_stat_t;

endpackage

/* hw/rtl/srrw_ctrl.sv */
// ----------------------------------------------------------------------------
// srrw_ctrl
// request sequencer: capture, evaluate, optional release walk, result handoff
// ----------------------------------------------------------------------------
module srrw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  srrw_pkg::dp_stat_t stat,
  output srrw_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result register can take a new value this cycle
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    out_valid_nxt   = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.deliver) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WALK;
        end else if (out_free) begin
          cmd.eval_commit = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_WALK: begin
        if (out_free) begin
          cmd.walk_commit = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/srrw_dp.sv */
// ----------------------------------------------------------------------------
// srrw_dp
// window state, window check, release walk and result register
// ----------------------------------------------------------------------------
module srrw_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srrw_pkg::dp_cmd_t                   cmd,
  output srrw_pkg::dp_stat_t                  stat,
  input  logic [srrw_pkg::IN_TDATA_W-1:0]     in_data,
  output logic [srrw_pkg::OUT_TDATA_W-1:0]    out_data
);

  // window state
  logic [srrw_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic [srrw_pkg::SEQ_W-1:0]  last_r, last_nxt;
  logic [srrw_pkg::MAP_W-1:0]  map_r, map_nxt;
  logic [srrw_pkg::FREE_W-1:0] free_r, free_nxt;
  logic [srrw_pkg::MAP_W-1:0]  rot_r, rot_nxt;

  // result register
  logic [srrw_pkg::ST_W-1:0]   ost_r, ost_nxt;
  logic [srrw_pkg::CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic [srrw_pkg::SEQ_W-1:0]  olast_r, olast_nxt;
  logic [srrw_pkg::FREE_W-1:0] ofree_r, ofree_nxt;

  // evaluation terms
  logic [srrw_pkg::SEQ_W-1:0]    seq_dist;
  logic [srrw_pkg::POS_W-1:0]    pos;
  logic [srrw_pkg::MAP_W-1:0]    bit_vec;
  logic [srrw_pkg::MAP_W-1:0]    marked;
  logic [2*srrw_pkg::MAP_W-1:0]  dbl_rot;
  logic                          hit;
  logic                          in_win;
  logic                          is_next;
  logic                          do_buffer;

  // walk terms
  logic [srrw_pkg::RUN_W-1:0]    run_len;
  logic [srrw_pkg::MAP_W-1:0]    low_mask;
  logic [srrw_pkg::MAP_W-1:0]    cleared;
  logic [2*srrw_pkg::MAP_W-1:0]  dbl_back;
  logic [srrw_pkg::RUN_W:0]      free_sum;
  logic [srrw_pkg::FREE_W-1:0]   free_walk;
  logic [srrw_pkg::SEQ_W-1:0]    last_walk;

  // window check on the latched number
  assign seq_dist  = seq_r - last_r;
  assign pos       = seq_r[srrw_pkg::POS_W-1:0];
  assign bit_vec   = srrw_pkg::MAP_W'(1) << pos;
  assign hit       = |(map_r & bit_vec);
  assign in_win    = (seq_dist != '0) && (seq_dist < srrw_pkg::SEQ_W'(srrw_pkg::MAP_W));
  assign is_next   = (seq_dist == srrw_pkg::SEQ_W'(1));
  assign do_buffer = in_win && !hit && !is_next && (free_r != '0);
  assign stat.deliver = in_win && !hit && is_next;

  // rotate the marked map so the next expected slot sits at bit zero
  assign marked  = map_r | bit_vec;
  assign dbl_rot = {marked, marked} >> pos;

  // length of the run of marks from bit zero
  always_comb begin
    run_len = srrw_pkg::RUN_W'(srrw_pkg::MAP_W);
    for (int i = srrw_pkg::MAP_W - 1; i >= 0; i--) begin
      if (!rot_r[i]) run_len = srrw_pkg::RUN_W'(i);
    end
  end

  // clear the released run and rotate back into place
  always_comb begin
    for (int i = 0; i < srrw_pkg::MAP_W; i++) begin
      low_mask[i] = (srrw_pkg::RUN_W'(i) < run_len);
    end
  end
  assign cleared  = rot_r & ~low_mask;
  assign dbl_back = {cleared, cleared} << pos;

  // advance last in-order number and return slots, saturating at capacity
  assign last_walk = last_r + srrw_pkg::SEQ_W'(run_len);
  assign free_sum  = (srrw_pkg::RUN_W+1)'(free_r) + (srrw_pkg::RUN_W+1)'(run_len)
                     - (srrw_pkg::RUN_W+1)'(1);
  assign free_walk = (free_sum > (srrw_pkg::RUN_W+1)'(srrw_pkg::WINDOW_SLOTS)) ?
                     srrw_pkg::WINDOW_SLOTS : free_sum[srrw_pkg::FREE_W-1:0];

  // next values
  always_comb begin
    seq_nxt   = seq_r;
    last_nxt  = last_r;
    map_nxt   = map_r;
    free_nxt  = free_r;
    rot_nxt   = rot_r;
    ost_nxt   = ost_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    ofree_nxt = ofree_r;
    if (cmd.capture) begin
      seq_nxt = in_data[srrw_pkg::SEQ_W-1:0];
    end
    if (cmd.eval_commit) begin
      ocnt_nxt  = '0;
      olast_nxt = last_r;
      if (do_buffer) begin
        map_nxt   = map_r | bit_vec;
        free_nxt  = free_r - srrw_pkg::FREE_W'(1);
        ost_nxt   = srrw_pkg::ST_BUFFERED;
        ofree_nxt = free_r - srrw_pkg::FREE_W'(1);
      end else begin
        ost_nxt   = srrw_pkg::ST_IGNORED;
        ofree_nxt = free_r;
      end
    end
    if (cmd.walk_start) begin
      rot_nxt = dbl_rot[srrw_pkg::MAP_W-1:0];
    end
    if (cmd.walk_commit) begin
      map_nxt   = dbl_back[2*srrw_pkg::MAP_W-1:srrw_pkg::MAP_W];
      last_nxt  = last_walk;
      free_nxt  = free_walk;
      ost_nxt   = srrw_pkg::ST_DELIVERED;
      ocnt_nxt  = run_len[srrw_pkg::CNT_W-1:0];
      olast_nxt = last_walk;
      ofree_nxt = free_walk;
    end
  end

  // window state, reset to next expected zero and an empty map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '1;
      map_r  <= '0;
      free_r <= srrw_pkg::WINDOW_SLOTS;
    end else begin
      last_r <= last_nxt;
      map_r  <= map_nxt;
      free_r <= free_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    seq_r   <= seq_nxt;
    rot_r   <= rot_nxt;
    ost_r   <= ost_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
    ofree_r <= ofree_nxt;
  end

  // pack result, status in the low bits
  assign out_data = {4'b0000, ofree_r, olast_r, ocnt_r, ost_r};

endmodule

/* hw/rtl/selective_repeat_receive_window.sv */
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// receiver side of a selective-repeat window over 8-bit sequence numbers
// ----------------------------------------------------------------------------
//  channel | dir | tdata bits | fields (lsb first)
//  in_     | in  | 8          | seq_number[7:0]
//  out_    | out | 24         | status[1:0] delivered_count[6:2]
//          |     |            | last_in_order_out[14:7] free_slots_out[19:15]
//
//  one request at a time: an ignored or buffered number goes through capture and
//  window check; an in-order delivery adds a release walk with a run priority
//  encode over the 32-bit map.
//  synchronous active-low reset: last in-order 255, empty map, 31 free slots.
//  a finished result sits in the output register; a new request is taken
//  while it waits, and the block stalls before its next commit until it drains.
// ----------------------------------------------------------------------------
`include "selective_repeat_receive_window_defines.svh"

module selective_repeat_receive_window (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [srrw_pkg::IN_TDATA_W-1:0]     in_tdata,   // seq_number[7:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[1:0], delivered_count[6:2], last_in_order_out[14:7],
  // free_slots_out[19:15], zero fill[23:20]
  output logic [srrw_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  srrw_pkg::dp_cmd_t  cmd;
  srrw_pkg::dp_stat_t stat;

  // sequencer
  srrw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // window datapath
  srrw_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_tdata),
    .out_data (out_tdata)
  );

  // result fields for checks
  logic [srrw_pkg::ST_W-1:0]   chk_status;
  logic [srrw_pkg::CNT_W-1:0]  chk_count;
  logic [srrw_pkg::FREE_W-1:0] chk_free;

  assign chk_status = out_tdata[1:0];
  assign chk_count  = out_tdata[6:2];
  assign chk_free   = out_tdata[19:15];

  // a delivery always releases at least one packet
  `SRRW_ASSERT_NOW(a_deliver_count, clk, rst_n,
    out_tvalid && (chk_status == srrw_pkg::ST_DELIVERED), chk_count != '0,
    "delivered result with zero count")

  // ignored and buffered results release nothing
  `SRRW_ASSERT_NOW(a_other_count, clk, rst_n,
    out_tvalid && (chk_status != srrw_pkg::ST_DELIVERED), chk_count == '0,
    "non-delivered result with nonzero count")

  // free slots never exceed the window capacity
  `SRRW_ASSERT_NOW(a_free_cap, clk, rst_n,
    out_tvalid, chk_free <= srrw_pkg::WINDOW_SLOTS,
    "free slot count above capacity")

  // one request in flight: no new request right after an accept
  `SRRW_ASSERT_NEXT(a_one_in_flight, clk, rst_n,
    in_tvalid && in_tready, !in_tready,
    "request accepted while previous one in flight")

endmodule

/* tb/tb_selective_repeat_receive_window.sv */
// ----------------------------------------------------------------------------
// tb_selective_repeat_receive_window
// Drives received sequence numbers into the receive window and checks every
// result against an in-bench window model: directed edge cases first, then
// reorder-heavy random traffic with random idling on both streams and one
// long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_selective_repeat_receive_window;

  localparam int MAX_AHEAD   = 31;
  localparam int TOTAL_ITEMS = 700;

  typedef struct packed {
    logic [srrw_pkg::ST_W-1:0]   status;
    logic [srrw_pkg::CNT_W-1:0]  count;
    logic [srrw_pkg::SEQ_W-1:0]  last;
    logic [srrw_pkg::FREE_W-1:0] free;
  } window_outcome_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [srrw_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [srrw_pkg::OUT_TDATA_W-1:0] out_tdata;

  // window model state
  logic [srrw_pkg::SEQ_W-1:0]  win_last;
  logic [srrw_pkg::MAP_W-1:0]  win_map;
  logic [srrw_pkg::FREE_W-1:0] win_free;

  window_outcome_t outcome_q[$];
  window_outcome_t want_res;
  int              mismatches = 0;
  int              items_sent = 0;
  bit              in_idle_on = 1'b1;
  bit              out_idle_on = 1'b1;
  int              hold_req = 0;

  selective_repeat_receive_window u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of one received number: window check, buffering, release walk
  function automatic window_outcome_t advance_window(
    input logic [srrw_pkg::SEQ_W-1:0] seq
  );
    window_outcome_t            res;
    logic [srrw_pkg::SEQ_W-1:0] dist_ahead;
    logic [srrw_pkg::POS_W-1:0] pos;
    int                         run;
    int                         step;
    dist_ahead = seq - win_last;
    pos = seq[srrw_pkg::POS_W-1:0];
    run = 0;
    step = 0;
    res.status = srrw_pkg::ST_IGNORED;
    if (dist_ahead != '0 && dist_ahead <= srrw_pkg::SEQ_W'(MAX_AHEAD) && !win_map[pos]) begin
      if (dist_ahead != srrw_pkg::SEQ_W'(1)) begin
        // out of order: hold it if a slot is free
        if (win_free != '0) begin
          win_map[pos] = 1'b1;
          win_free = win_free - 1'b1;
          res.status = srrw_pkg::ST_BUFFERED;
        end
      end else begin
        // next expected: release the run of consecutive marks
        win_map[pos] = 1'b1;
        while (step < srrw_pkg::MAP_W && win_map[pos]) begin
          win_map[pos] = 1'b0;
          win_last = win_last + 1'b1;
          pos = pos + 1'b1;
          run++;
          if (step != 0 && win_free < srrw_pkg::WINDOW_SLOTS) win_free = win_free + 1'b1;
          step++;
        end
        res.status = srrw_pkg::ST_DELIVERED;
      end
    end
    res.count = srrw_pkg::CNT_W'(run);
    res.last = win_last;
    res.free = win_free;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // offer one request and wait until the block takes it
  task automatic send_seq(input logic [srrw_pkg::SEQ_W-1:0] seq);
    window_outcome_t res;
    int              gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata <= srrw_pkg::IN_TDATA_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= seq;
    do @(posedge clk); while (!in_tready);
    res = advance_window(seq);
    items_sent++;
    outcome_q.push_back(res);
  endtask

  // pick a number for reorder-heavy traffic
  function automatic logic [srrw_pkg::SEQ_W-1:0] pick_seq();
    int                         r;
    int                         d;
    int                         marked[$];
    logic [srrw_pkg::SEQ_W-1:0] cand;
    r = $urandom_range(0, 99);
    if (r < 35) return win_last + 1'b1;
    if (r < 70) return win_last + srrw_pkg::SEQ_W'($urandom_range(2, 8));
    if (r < 80) return win_last + srrw_pkg::SEQ_W'($urandom_range(9, MAX_AHEAD));
    if (r < 88) begin
      // repeat a number that is already buffered
      for (d = 2; d <= MAX_AHEAD; d++) begin
        cand = win_last + srrw_pkg::SEQ_W'(d);
        if (win_map[cand[srrw_pkg::POS_W-1:0]]) marked.push_back(d);
      end
      if (marked.size() != 0)
        return win_last +
               srrw_pkg::SEQ_W'(marked[$urandom_range(0, marked.size() - 1)]);
    end
    return srrw_pkg::SEQ_W'($urandom_range(0, 255));
  endfunction

  // buffer every slot past the next expected in shuffled order, then release it all
  task automatic fill_window();
    int                         dists[30];
    int                         i;
    int                         j;
    int                         t;
    logic [srrw_pkg::SEQ_W-1:0] base;
    base = win_last;
    for (i = 0; i < 30; i++) dists[i] = i + 2;
    for (i = 29; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = dists[i];
      dists[i] = dists[j];
      dists[j] = t;
    end
    for (i = 0; i < 30; i++) send_seq(base + srrw_pkg::SEQ_W'(dists[i]));
    send_seq(base + 1'b1);
  endtask

  task automatic test_window_edges();
    send_seq(8'd255);   // distance 0 right after reset
    send_seq(8'd31);    // distance 32
    send_seq(8'd128);
    send_seq(8'd30);    // farthest slot in the window
    send_seq(8'd0);     // next expected
    send_seq(8'd0);     // now behind the window
    send_seq(8'd32);
    send_seq(8'd255);
  endtask

  task automatic test_reorder_and_duplicates();
    logic [srrw_pkg::SEQ_W-1:0] base;
    base = win_last;
    send_seq(base + 8'd3);
    send_seq(base + 8'd2);
    send_seq(base + 8'd2);   // duplicate
    send_seq(base + 8'd4);
    send_seq(base + 8'd1);   // releases a run of four
    send_seq(8'd30);         // still buffered from before
    send_seq(win_last + 1'b1);
    send_seq(win_last + 8'd170);
  endtask

  task automatic test_back_to_back();
    int i;
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    for (i = 0; i < 40; i++) send_seq(pick_seq());
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // receiver stops for a long time while requests keep coming
  task automatic test_output_backpressure();
    int i;
    in_idle_on = 1'b0;
    hold_req = 200;
    for (i = 0; i < 12; i++) send_seq(pick_seq());
    in_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    fill_window();
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 199) == 0) fill_window();
      else send_seq(pick_seq());
    end
  endtask

  // receiver side: random stalls, and a counted hold when asked
  initial begin
    int len;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_tready <= 1'b0;
        len = hold_req;
        hold_req = 0;
        repeat (len - 1) @(negedge clk);
      end else if (out_idle_on && $urandom_range(0, 99) < 35) begin
        out_tready <= 1'b0;
        len = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (len - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with nothing pending", int'(out_tdata), 0);
      end else begin
        want_res = outcome_q.pop_front();
        if (out_tdata[1:0] != want_res.status)
          report_mismatch("status", int'(out_tdata[1:0]), int'(want_res.status));
        if (out_tdata[6:2] != want_res.count)
          report_mismatch("delivered_count", int'(out_tdata[6:2]),
                          int'(want_res.count));
        if (out_tdata[14:7] != want_res.last)
          report_mismatch("last_in_order_out", int'(out_tdata[14:7]),
                          int'(want_res.last));
        if (out_tdata[19:15] != want_res.free)
          report_mismatch("free_slots_out", int'(out_tdata[19:15]),
                          int'(want_res.free));
      end
    end
  end

  // main sequence
  initial begin
    win_last = 8'd255;
    win_map = '0;
    win_free = srrw_pkg::WINDOW_SLOTS;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_window_edges();
    test_reorder_and_duplicates();
    test_back_to_back();
    test_output_backpressure();
    test_random_traffic();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/srrw_pkg.sv
hw/rtl/srrw_ctrl.sv
hw/rtl/srrw_dp.sv
hw/rtl/selective_repeat_receive_window.sv
tb/tb_selective_repeat_receive_window.sv
